/* rtl/afs_pkg.sv */
package afs_pkg;

  localparam int unsigned FrameMinSizeDef = 4096;
  localparam int unsigned NameBytesDef    = 8;
  localparam int unsigned MaxResults      = 62;
  localparam int unsigned PosW            = 7;

  localparam logic [7:0] FrameEnd = 8'hCE;

  typedef enum logic [1:0] {
    OP_CMD  = 2'd0,
    OP_MSG  = 2'd1,
    OP_OPEN = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_FLOW  = 3'd0,
    CFG_CHAN  = 3'd1,
    CFG_XLEN  = 3'd2,
    CFG_XNAME = 3'd3,
    CFG_RLEN  = 3'd4,
    CFG_RKEY  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JOB_OPEN,
    JOB_CMD,
    JOB_MSG,
    JOB_REJ
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic [PosW-1:0]   start;
    logic [PosW-1:0]   stop;
    logic              empty;
    logic [7:0]        data;
    logic [15:0]       chan;
    logic [15:0]       cls;
    logic [15:0]       meth;
    logic [31:0]       total;
    logic [31:0]       frag;
  } job_t;

  typedef struct packed {
    logic        flow;
    logic [15:0] chan;
    logic [3:0]  el;
    logic [3:0]  rl;
    logic [63:0] xname;
    logic [63:0] rkey;
  } cfg_t;

  localparam logic [7:0] OpenHdr [8] = '{8'h41, 8'h4D, 8'h51, 8'h50,
                                         8'h01, 8'h01, 8'h00, 8'h09};

endpackage

/* rtl/afs_ifc.sv */
interface afs_in_if;
  import afs_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] cmd_channel;
  logic [15:0] cmd_class;
  logic [15:0] cmd_method;
  logic [31:0] total_length;
  logic [7:0]  data_byte;
  modport source (output valid, operation, cmd_channel, cmd_class, cmd_method, total_length,
                  data_byte, input ready);
  modport sink (input valid, operation, cmd_channel, cmd_class, cmd_method, total_length,
                data_byte, output ready);
endinterface

interface afs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       rejected;
  modport source (output valid, out_byte, last, rejected, input ready);
  modport sink (input valid, out_byte, last, rejected, output ready);
endinterface

/* rtl/amqp_frame_serializer_unit.sv */
// latency: the first byte of an item is registered in the job queue and then in the output register
// throughput: one output word per cycle unless stalled; an item of n words holds the back end
// continuing payload and argument words are accepted while the job queue has room, before earlier items finish
// a two-entry job queue sits between the classifier and the byte sequencer
// reset clears all sequencing state and configuration; no memory needs clearing
module amqp_frame_serializer_unit import afs_pkg::*; #(
  parameter int unsigned FrameMinSize = FrameMinSizeDef,
  parameter int unsigned NameBytes    = NameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  afs_in_if.sink      in_ch,
  afs_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic        flow_q;
  logic [15:0] chan_q;
  logic [3:0]  xlen_q, rlen_q;
  logic [63:0] xname_q, rkey_q;
  cfg_t        cfg;

  logic push, full, pop, qvalid;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q  <= 1'b0;
      chan_q  <= '0;
      xlen_q  <= '0;
      rlen_q  <= '0;
      xname_q <= '0;
      rkey_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLOW:  flow_q  <= cfg_data_i[0];
        CFG_CHAN:  chan_q  <= cfg_data_i[15:0];
        CFG_XLEN:  xlen_q  <= cfg_data_i[3:0];
        CFG_XNAME: xname_q <= cfg_data_i;
        CFG_RLEN:  rlen_q  <= cfg_data_i[3:0];
        CFG_RKEY:  rkey_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg       = '0;
    cfg.flow  = flow_q;
    cfg.chan  = chan_q;
    cfg.el    = (xlen_q > 4'(NameBytes)) ? 4'(NameBytes) : xlen_q;
    cfg.rl    = (rlen_q > 4'(NameBytes)) ? 4'(NameBytes) : rlen_q;
    cfg.xname = xname_q;
    cfg.rkey  = rkey_q;
  end

  afs_front #(.FrameMinSize(FrameMinSize)) u_front (
    .clk_i,
    .rst_ni,
    .valid_i        (in_ch.valid),
    .ready_o        (in_ch.ready),
    .operation_i    (in_ch.operation),
    .cmd_channel_i  (in_ch.cmd_channel),
    .cmd_class_i    (in_ch.cmd_class),
    .cmd_method_i   (in_ch.cmd_method),
    .total_length_i (in_ch.total_length),
    .data_byte_i    (in_ch.data_byte),
    .cfg_i          (cfg),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  afs_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .job_o   (job_out)
  );

  afs_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg),
    .valid_i    (qvalid),
    .job_i      (job_out),
    .pop_o      (pop),
    .valid_o    (out_ch.valid),
    .ready_i    (out_ch.ready),
    .out_byte_o (out_ch.out_byte),
    .last_o     (out_ch.last),
    .rejected_o (out_ch.rejected)
  );

endmodule

/* rtl/afs_front.sv */
module afs_front import afs_pkg::*; #(
  parameter int unsigned FrameMinSize = FrameMinSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] cmd_channel_i,
  input  logic [15:0] cmd_class_i,
  input  logic [15:0] cmd_method_i,
  input  logic [31:0] total_length_i,
  input  logic [7:0]  data_byte_i,
  input  cfg_t        cfg_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam int unsigned FragW = $clog2(FrameMinSize);
  localparam logic [31:0] FragMax = 32'(FrameMinSize - 8);

  logic             inprog_q, inprog_d;
  logic             kind_q, kind_d;
  logic [31:0]      left_q, left_d;
  logic [FragW-1:0] fleft_q, fleft_d;

  logic [PosW-1:0]  base;
  logic [31:0]      frag_new, tot_min, left_min;
  logic [6:0]       need;
  logic [31:0]      lm1;
  logic [FragW-1:0] fl;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  assign base     = PosW'(7'd39 + {3'd0, cfg_i.el} + {3'd0, cfg_i.rl});
  assign tot_min  = (total_length_i < FragMax) ? total_length_i : FragMax;
  assign left_min = (left_q < FragMax) ? left_q : FragMax;
  assign lm1      = left_q - 32'd1;

  always_comb begin
    job_o        = '0;
    job_o.kind   = JOB_REJ;
    job_o.data   = data_byte_i;
    job_o.chan   = cmd_channel_i;
    job_o.cls    = cmd_class_i;
    job_o.meth   = cmd_method_i;
    job_o.total  = total_length_i;
    inprog_d     = inprog_q;
    kind_d       = kind_q;
    left_d       = left_q;
    fleft_d      = fleft_q;
    frag_new     = '0;
    fl           = '0;
    need         = 7'd55 + {3'd0, cfg_i.el} + {3'd0, cfg_i.rl};
    case (operation_i)
      OP_OPEN: begin
        if (!inprog_q) begin
          job_o.kind  = JOB_OPEN;
          job_o.start = '0;
          job_o.stop  = PosW'(7);
        end
      end
      OP_CMD: begin
        if (!inprog_q) begin
          if (total_length_i <= 32'hFFFF_FFFB) begin
            job_o.kind  = JOB_CMD;
            job_o.start = '0;
            if (total_length_i == '0) begin
              job_o.empty = 1'b1;
              job_o.stop  = PosW'(11);
            end else begin
              left_d      = total_length_i - 32'd1;
              kind_d      = 1'b0;
              inprog_d    = left_d != '0;
              job_o.stop  = inprog_d ? PosW'(11) : PosW'(12);
            end
          end
        end else if (!kind_q) begin
          job_o.kind  = JOB_CMD;
          job_o.start = PosW'(11);
          left_d      = lm1;
          inprog_d    = lm1 != '0;
          job_o.stop  = inprog_d ? PosW'(11) : PosW'(12);
        end
      end
      OP_MSG: begin
        if (cfg_i.flow) begin
          if (!inprog_q) begin
            if (total_length_i != '0) begin
              need = need + 7'd8 + ((tot_min == 32'd1) ? 7'd1 : 7'd0);
            end
            if (need <= 7'(MaxResults)) begin
              job_o.kind  = JOB_MSG;
              job_o.start = '0;
              kind_d      = 1'b1;
              if (total_length_i == '0) begin
                job_o.stop = base - PosW'(1);
                inprog_d   = 1'b0;
                left_d     = '0;
                fleft_d    = '0;
              end else begin
                frag_new   = tot_min;
                job_o.frag = frag_new;
                fl         = FragW'(frag_new - 32'd1);
                fleft_d    = fl;
                left_d     = total_length_i - 32'd1;
                inprog_d   = left_d != '0;
                job_o.stop = base + PosW'(7) + ((fl == '0) ? PosW'(1) : PosW'(0));
              end
            end
          end else if (kind_q) begin
            job_o.kind = JOB_MSG;
            if (fleft_q == '0) begin
              frag_new    = left_min;
              job_o.frag  = frag_new;
              job_o.start = base;
              fl          = FragW'(frag_new - 32'd1);
            end else begin
              job_o.start = base + PosW'(7);
              fl          = fleft_q - FragW'(1);
            end
            fleft_d    = fl;
            left_d     = lm1;
            inprog_d   = lm1 != '0;
            job_o.stop = base + PosW'(7) + ((fl == '0) ? PosW'(1) : PosW'(0));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inprog_q <= 1'b0;
      kind_q   <= 1'b0;
      left_q   <= '0;
      fleft_q  <= '0;
    end else if (push_o) begin
      inprog_q <= inprog_d;
      kind_q   <= kind_d;
      left_q   <= left_d;
      fleft_q  <= fleft_d;
    end
  end

endmodule

/* rtl/afs_queue.sv */
module afs_queue import afs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* rtl/afs_back.sv */
module afs_back import afs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       rejected_o
);

  logic            mid_q, mid_d;
  logic [PosW-1:0] pos_q, pos_d, pos;
  logic            ovalid_q;
  logic [7:0]      obyte_q;
  logic            olast_q, orej_q;
  logic            adv, last;
  logic [7:0]      byte_v;

  logic [PosW-1:0] e, r, m, q, b, ni;
  logic [2:0]      sh;
  logic [7:0]      msize;

  assign adv   = valid_i && (!ovalid_q || ready_i);
  assign pos   = mid_q ? pos_q : job_i.start;
  assign last  = (job_i.kind == JOB_REJ) || (pos == job_i.stop);
  assign pop_o = adv && last;

  assign e     = PosW'(cfg_i.el);
  assign r     = PosW'(cfg_i.rl);
  assign m     = PosW'(17) + e + r;
  assign q     = pos - m;
  assign b     = q - PosW'(22);
  assign msize = 8'd9 + {4'd0, cfg_i.el} + {4'd0, cfg_i.rl};

  function automatic logic [7:0] pick(input logic [63:0] w, input logic [2:0] s);
    return w[{s, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] be32(input logic [31:0] w, input logic [1:0] k);
    return w[{2'd3 - k, 3'b000} +: 8];
  endfunction

  always_comb begin
    byte_v = '0;
    ni     = '0;
    sh     = '0;
    case (job_i.kind)
      JOB_OPEN: byte_v = OpenHdr[pos[2:0]];
      JOB_CMD: begin
        case (pos)
          PosW'(0):  byte_v = 8'd1;
          PosW'(1):  byte_v = job_i.chan[15:8];
          PosW'(2):  byte_v = job_i.chan[7:0];
          PosW'(3), PosW'(4), PosW'(5), PosW'(6):
            byte_v = be32(job_i.total + 32'd4, 2'(pos - PosW'(3)));
          PosW'(7):  byte_v = job_i.cls[15:8];
          PosW'(8):  byte_v = job_i.cls[7:0];
          PosW'(9):  byte_v = job_i.meth[15:8];
          PosW'(10): byte_v = job_i.meth[7:0];
          PosW'(11): byte_v = job_i.empty ? FrameEnd : job_i.data;
          default:   byte_v = FrameEnd;
        endcase
      end
      JOB_MSG: begin
        if (pos < PosW'(13)) begin
          case (pos)
            PosW'(0): byte_v = 8'd1;
            PosW'(1): byte_v = cfg_i.chan[15:8];
            PosW'(2): byte_v = cfg_i.chan[7:0];
            PosW'(6): byte_v = msize;
            PosW'(8): byte_v = 8'd60;
            PosW'(10): byte_v = 8'd40;
            default: byte_v = 8'd0;
          endcase
        end else if (pos == PosW'(13)) begin
          byte_v = {4'd0, cfg_i.el};
        end else if (pos < PosW'(14) + e) begin
          ni     = pos - PosW'(14);
          sh     = 3'(e - PosW'(1) - ni);
          byte_v = pick(cfg_i.xname, sh);
        end else if (pos == PosW'(14) + e) begin
          byte_v = {4'd0, cfg_i.rl};
        end else if (pos < PosW'(15) + e + r) begin
          ni     = pos - PosW'(15) - e;
          sh     = 3'(r - PosW'(1) - ni);
          byte_v = pick(cfg_i.rkey, sh);
        end else if (pos == PosW'(15) + e + r) begin
          byte_v = 8'd0;
        end else if (pos == PosW'(16) + e + r) begin
          byte_v = FrameEnd;
        end else if (q < PosW'(22)) begin
          case (q)
            PosW'(0): byte_v = 8'd2;
            PosW'(1): byte_v = cfg_i.chan[15:8];
            PosW'(2): byte_v = cfg_i.chan[7:0];
            PosW'(6): byte_v = 8'd14;
            PosW'(8): byte_v = 8'd60;
            PosW'(15), PosW'(16), PosW'(17), PosW'(18):
              byte_v = be32(job_i.total, 2'(q - PosW'(15)));
            PosW'(21): byte_v = FrameEnd;
            default: byte_v = 8'd0;
          endcase
        end else begin
          case (b)
            PosW'(0): byte_v = 8'd3;
            PosW'(1): byte_v = cfg_i.chan[15:8];
            PosW'(2): byte_v = cfg_i.chan[7:0];
            PosW'(3), PosW'(4), PosW'(5), PosW'(6):
              byte_v = be32(job_i.frag, 2'(b - PosW'(3)));
            PosW'(7): byte_v = job_i.data;
            default: byte_v = FrameEnd;
          endcase
        end
      end
      default: byte_v = 8'd0;
    endcase
  end

  always_comb begin
    mid_d = mid_q;
    pos_d = pos_q;
    if (adv) begin
      mid_d = !last;
      pos_d = pos + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q    <= 1'b0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      mid_q <= mid_d;
      pos_q <= pos_d;
      if (adv) begin
        ovalid_q <= 1'b1;
      end else if (ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      obyte_q <= byte_v;
      olast_q <= last;
      orej_q  <= job_i.kind == JOB_REJ;
    end
  end

  assign valid_o    = ovalid_q;
  assign out_byte_o = obyte_q;
  assign last_o     = olast_q;
  assign rejected_o = orej_q;

endmodule

/* bench/afs_checker.sv */
module afs_checker import afs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_chan,
  input  logic [15:0] in_cls,
  input  logic [15:0] in_meth,
  input  logic [31:0] in_total,
  input  logic [7:0]  in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        out_rej,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       rej;
  } wire_word_t;

  wire_word_t wire_q[$];

  logic        flow;
  logic [15:0] mchan;
  logic [3:0]  xlen, rlen;
  logic [63:0] xname, rkey;
  logic        busy;
  logic        kind_msg;
  logic [31:0] left;
  logic [12:0] frag_left;

  wire_word_t step_q[$];

  assign pending = wire_q.size();

  function automatic void put8(logic [7:0] v);
    wire_word_t w;
    w.b = v; w.last = 1'b0; w.rej = 1'b0;
    if (step_q.size() < MaxResults) step_q.push_back(w);
  endfunction

  function automatic void put16(logic [15:0] v);
    put8(v[15:8]); put8(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]); put16(v[15:0]);
  endfunction

  function automatic void put_name(logic [63:0] bytes, int len);
    put8(len[7:0]);
    for (int i = 0; i < len; i++) put8(8'(bytes >> (8 * (len - 1 - i))));
  endfunction

  function automatic void payload_word(logic [7:0] d);
    logic [31:0] f;
    if (frag_left == 0) begin
      f = (left < FrameMinSizeDef - 8) ? left : FrameMinSizeDef - 8;
      put8(8'd3); put16(mchan); put32(f);
      frag_left = f[12:0];
    end
    put8(d);
    frag_left--;
    left--;
    if (frag_left == 0) put8(FrameEnd);
    busy = (left != 0);
  endfunction

  function automatic void predict_frames(logic [1:0] op, logic [15:0] ch, logic [15:0] cls,
                                         logic [15:0] meth, logic [31:0] tot, logic [7:0] d);
    wire_word_t r;
    int el, rl, need;
    logic [31:0] first;
    logic refuse;
    step_q.delete();
    refuse = 1'b0;
    el = (xlen > NameBytesDef) ? NameBytesDef : xlen;
    rl = (rlen > NameBytesDef) ? NameBytesDef : rlen;
    case (op)
      OP_OPEN: begin
        if (busy) refuse = 1'b1;
        else for (int i = 0; i < 8; i++) put8(OpenHdr[i]);
      end
      OP_CMD: begin
        if (busy && kind_msg) refuse = 1'b1;
        else if (!busy) begin
          if (tot > 32'hFFFFFFFB) refuse = 1'b1;
          else begin
            put8(8'd1); put16(ch); put32(tot + 32'd4); put16(cls); put16(meth);
            if (tot == 0) put8(FrameEnd);
            else begin
              put8(d);
              left = tot - 1;
              kind_msg = 1'b0;
              busy = (left != 0);
              if (!busy) put8(FrameEnd);
            end
          end
        end else begin
          put8(d);
          left--;
          busy = (left != 0);
          if (!busy) put8(FrameEnd);
        end
      end
      OP_MSG: begin
        if (!flow) refuse = 1'b1;
        else if (busy && !kind_msg) refuse = 1'b1;
        else if (!busy) begin
          first = (tot < FrameMinSizeDef - 8) ? tot : FrameMinSizeDef - 8;
          need = 55 + el + rl;
          if (tot != 0) need += 8 + ((first == 1) ? 1 : 0);
          if (need > MaxResults) refuse = 1'b1;
          else begin
            put8(8'd1); put16(mchan); put32(32'(9 + el + rl));
            put16(16'd60); put16(16'd40); put16(16'd0);
            put_name(xname, el); put_name(rkey, rl);
            put8(8'd0); put8(FrameEnd);
            put8(8'd2); put16(mchan); put32(32'd14); put16(16'd60); put16(16'd0);
            put32(32'd0); put32(tot); put16(16'd0); put8(FrameEnd);
            kind_msg = 1'b1;
            frag_left = 0;
            left = tot;
            if (tot != 0) payload_word(d);
            else busy = 1'b0;
          end
        end else payload_word(d);
      end
      default: refuse = 1'b1;
    endcase
    if (refuse) begin
      r.b = 8'd0; r.last = 1'b1; r.rej = 1'b1;
      wire_q.push_back(r);
    end else begin
      step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) wire_q.push_back(step_q[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wire_word_t e;
    if (!rst_ni) begin
      flow <= 0; mchan <= 0; xlen <= 0; rlen <= 0; xname <= 0; rkey <= 0;
      busy = 0; kind_msg = 0; left = 0; frag_left = 0;
      fail_count <= 0;
      wire_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FLOW:  flow  <= cfg_data[0];
          CFG_CHAN:  mchan <= cfg_data[15:0];
          CFG_XLEN:  xlen  <= cfg_data[3:0];
          CFG_XNAME: xname <= cfg_data;
          CFG_RLEN:  rlen  <= cfg_data[3:0];
          CFG_RKEY:  rkey  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_frames(in_op, in_chan, in_cls, in_meth, in_total, in_data);
      if (out_valid && out_ready) begin
        if (wire_q.size() == 0) begin
          $error("unexpected word out_byte=%h", out_byte);
          fail_count <= fail_count + 1;
        end else begin
          e = wire_q.pop_front();
          if (e.rej != out_rej) begin
            $error("rejected: expected %b actual %b", e.rej, out_rej);
            fail_count <= fail_count + 1;
          end else if (e.last != out_last) begin
            $error("last: expected %b actual %b", e.last, out_last);
            fail_count <= fail_count + 1;
          end else if (!e.rej && e.b != out_byte) begin
            $error("out_byte: expected %h actual %h", e.b, out_byte);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/amqp_frame_serializer_unit_tb.sv */
module amqp_frame_serializer_unit_tb;
  import afs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = CFG_FLOW;
  logic [63:0] cfg_data = '0;
  int          fail_count, pending;
  int          src_idle = 0, snk_stall = 0;
  bit          hold_off = 1'b0;

  afs_in_if  in_ch();
  afs_out_if out_ch();

  amqp_frame_serializer_unit i_dut (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  afs_checker i_chk (
    .clk_i, .rst_ni,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.operation),
    .in_chan(in_ch.cmd_channel), .in_cls(in_ch.cmd_class), .in_meth(in_ch.cmd_method),
    .in_total(in_ch.total_length), .in_data(in_ch.data_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_byte(out_ch.out_byte),
    .out_last(out_ch.last), .out_rej(out_ch.rejected),
    .cfg_we, .cfg_idx, .cfg_data, .fail_count, .pending
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 0; in_ch.operation = OP_CMD; in_ch.cmd_channel = 0; in_ch.cmd_class = 0;
    in_ch.cmd_method = 0; in_ch.total_length = 0; in_ch.data_byte = 0;
    out_ch.ready = 0;
  end

  always @(negedge clk_i) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_stall);
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic setup(logic fl, logic [15:0] ch, logic [3:0] xl, logic [63:0] xn,
                       logic [3:0] rl, logic [63:0] rk);
    drain();
    write_reg(CFG_FLOW, 64'(fl)); write_reg(CFG_CHAN, 64'(ch)); write_reg(CFG_XLEN, 64'(xl));
    write_reg(CFG_XNAME, xn); write_reg(CFG_RLEN, 64'(rl)); write_reg(CFG_RKEY, rk);
  endtask

  task automatic send_word(logic [1:0] op, logic [31:0] tot, logic [7:0] d);
    while ($urandom_range(99) < src_idle) @(negedge clk_i);
    in_ch.valid = 1'b1; in_ch.operation = op;
    in_ch.cmd_channel = 16'($urandom); in_ch.cmd_class = 16'($urandom);
    in_ch.cmd_method = 16'($urandom);
    in_ch.total_length = tot; in_ch.data_byte = d;
    while (!in_ch.ready) @(negedge clk_i);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_job(logic [1:0] op, int n);
    if (n == 0) send_word(op, 32'd0, 8'($urandom));
    else for (int i = 0; i < n; i++)
      send_word(op, (i == 0) ? 32'(n) : 32'($urandom), 8'($urandom));
  endtask

  task automatic random_part(int cnt);
    int r;
    for (int k = 0; k < cnt; ) begin
      r = $urandom_range(99);
      if (r < 45) begin
        r = $urandom_range(5); send_job(OP_CMD, r); k += (r == 0) ? 1 : r;
      end else if (r < 85) begin
        r = $urandom_range(4); send_job(OP_MSG, r); k += (r == 0) ? 1 : r;
      end else if (r < 92) begin
        send_word(OP_OPEN, 32'($urandom), 8'($urandom)); k++;
      end else begin
        send_word(OP_RSVD, 32'($urandom), 8'($urandom));
        send_word(OP_CMD, 32'd3, 8'($urandom)); send_word(OP_MSG, 32'($urandom), 8'($urandom));
        send_word(OP_OPEN, 32'd0, 8'd0); send_word(OP_CMD, 32'd0, 8'd0);
        send_word(OP_CMD, 32'd0, 8'd0);
        k += 6;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed
    send_word(OP_OPEN, 0, 8'hFF);
    send_word(OP_MSG, 1, 8'h55);
    send_job(OP_CMD, 0);
    send_word(OP_CMD, 32'hFFFFFFFC, 8'h00);
    send_word(OP_CMD, 32'hFFFFFFFB, 8'hFF);
    send_word(OP_OPEN, 0, 0);
    send_word(OP_MSG, 0, 0);
    send_word(OP_RSVD, 32'hFFFFFFFF, 8'hAA);
    setup(1, 16'hFFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_word(OP_MSG, 1, 8'h12);
    send_word(OP_MSG, 0, 0);
    send_word(OP_MSG, 32'hFFFFFFFF, 8'h01);
    send_word(OP_CMD, 1, 0);
    setup(1, 16'h0000, 4'd0, 64'h0, 4'd0, 64'h0);
    send_word(OP_CMD, 32'hFFFFFFFF, 8'h01);
    send_job(OP_MSG, 3);
    send_word(OP_MSG, 2, 8'h01);
    setup(0, 16'h1234, 4'd3, 64'hAABBCC, 4'd1, 64'h7F);
    send_word(OP_MSG, 0, 0);
    setup(1, 16'h1234, 4'd3, 64'hAABBCC, 4'd1, 64'h7F);
    send_job(OP_MSG, 2);
    send_job(OP_CMD, 2);
    // random phases
    src_idle = 0; snk_stall = 0;
    random_part(60);
    setup(1, 16'($urandom), 4'($urandom_range(8)), {$urandom, $urandom},
          4'($urandom_range(8)), {$urandom, $urandom});
    src_idle = 79; snk_stall = 0;
    random_part(60);
    drain();
    src_idle = 0; snk_stall = 79;
    random_part(60);
    setup(1, 16'($urandom), 4'($urandom_range(15)), {$urandom, $urandom},
          4'($urandom_range(15)), {$urandom, $urandom});
    src_idle = 33; snk_stall = 33;
    random_part(60);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_part(20);
    join
    drain();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

/* amqp_frame_serializer_unit.f */
rtl/afs_pkg.sv
rtl/afs_ifc.sv
rtl/afs_front.sv
rtl/afs_queue.sv
rtl/afs_back.sv
rtl/amqp_frame_serializer_unit.sv
bench/afs_checker.sv
bench/amqp_frame_serializer_unit_tb.sv
